@@ hw/rtl/dls_pkg.sv @@
`timescale 1ns / 1ps

package dls_pkg;

	localparam int NODE_W  = 4;
	localparam int DEPTH_W = 4;
	// node fields are 4 bits wide, so at most this many distinct nodes exist
	localparam int NODE_SPAN = 2 ** NODE_W;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_SEARCHING = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_CAP       = 2'd3
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [NODE_W-1:0] edge_from;
		logic [NODE_W-1:0] edge_to;
		logic [NODE_W-1:0] start_node;
		logic [NODE_W-1:0] goal_node;
		logic [DEPTH_W-1:0] depth_limit;
	} request_t;

	typedef struct packed {
		logic [NODE_W-1:0]  visited_node;
		logic [DEPTH_W-1:0] visit_depth;
		logic [1:0]         status;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [NODE_W-1:0]  node;
	} stack_entry_t;

	typedef struct packed {
		logic init;
		logic pop;
		logic push;
	} stack_cmd_t;

endpackage

@@ hw/rtl/dls_stack.sv @@
`timescale 1ns / 1ps

module dls_stack #(
	parameter int STACK_SIZE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dls_pkg::stack_cmd_t   cmd,
	input  dls_pkg::stack_entry_t wr_entry,
	output dls_pkg::stack_entry_t rd_entry,
	output logic                  empty
);

	localparam int IDX_W = (STACK_SIZE > 1) ? $clog2(STACK_SIZE) : 1;
	localparam int SP_W  = $clog2(STACK_SIZE + 1);

	dls_pkg::stack_entry_t mem [STACK_SIZE];
	dls_pkg::stack_entry_t rd_q;
	logic [SP_W-1:0]       sp_q;
	logic [SP_W-1:0]       sp_dec;
	logic                  full;
	logic                  push_ok;

	assign sp_dec   = sp_q - SP_W'(1);
	assign full     = (sp_q == SP_W'(STACK_SIZE));
	assign push_ok  = cmd.push && !full;
	assign empty    = (sp_q == '0);
	assign rd_entry = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.init) begin
			sp_q <= SP_W'(1);
		end else if (cmd.pop) begin
			sp_q <= sp_dec;
		end else if (push_ok) begin
			sp_q <= sp_q + SP_W'(1);
		end
	end

	// pushes beyond the top are dropped
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			mem[0] <= wr_entry;
		end else if (push_ok) begin
			mem[sp_q[IDX_W-1:0]] <= wr_entry;
		end
		if (cmd.pop) begin
			rd_q <= mem[sp_dec[IDX_W-1:0]];
		end
	end

endmodule

@@ hw/rtl/dls_adj.sv @@
`timescale 1ns / 1ps

module dls_adj #(
	parameter int NODE_COUNT = 16,
	parameter int MAX_DEGREE = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                add_en,
	input  logic [dls_pkg::NODE_W-1:0]          add_from,
	input  logic [dls_pkg::NODE_W-1:0]          add_to,
	input  logic                                rd_en,
	input  logic [dls_pkg::NODE_W-1:0]          rd_node,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]     rd_slot,
	input  logic [dls_pkg::NODE_W-1:0]          lookup_node,
	output logic [$clog2(MAX_DEGREE+1)-1:0]     deg,
	output logic [dls_pkg::NODE_W-1:0]          succ
);

	localparam int NODES_EFF = (NODE_COUNT < dls_pkg::NODE_SPAN) ? NODE_COUNT
	                                                            : dls_pkg::NODE_SPAN;
	localparam int NIDX_W    = $clog2(NODES_EFF);
	localparam int CNT_W     = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH     = NODES_EFF * MAX_DEGREE;
	localparam int ADDR_W    = $clog2(DEPTH);

	logic [CNT_W-1:0]          cnt_q [NODES_EFF];
	logic [dls_pkg::NODE_W-1:0] mem [DEPTH];
	logic [dls_pkg::NODE_W-1:0] succ_q;

	logic             from_ok;
	logic             to_ok;
	logic             lk_ok;
	logic [CNT_W-1:0] from_cnt;
	logic             add_ok;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign from_ok  = int'(add_from) < NODE_COUNT;
	assign to_ok    = int'(add_to) < NODE_COUNT;
	assign lk_ok    = int'(lookup_node) < NODE_COUNT;
	assign from_cnt = cnt_q[add_from[NIDX_W-1:0]];
	assign add_ok   = add_en && from_ok && to_ok && (from_cnt < CNT_W'(MAX_DEGREE));

	assign wr_addr = ADDR_W'(add_from[NIDX_W-1:0]) * ADDR_W'(MAX_DEGREE) + ADDR_W'(from_cnt);
	assign rd_addr = ADDR_W'(rd_node[NIDX_W-1:0]) * ADDR_W'(MAX_DEGREE) + ADDR_W'(rd_slot);

	// a node outside the graph has no successors
	assign deg  = lk_ok ? cnt_q[lookup_node[NIDX_W-1:0]] : '0;
	assign succ = succ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES_EFF; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (add_ok) begin
			cnt_q[add_from[NIDX_W-1:0]] <= from_cnt + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (add_ok) begin
			mem[wr_addr] <= add_to;
		end
		if (rd_en) begin
			succ_q <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/depth_limited_graph_search.sv @@
`timescale 1ns / 1ps
// Edge add: busy stays low, no result.
// Search: the first result is the start node, strobed after its pop and evaluate steps;
// each visit is a stack pop and an evaluate step, plus an expand step per successor pushed
// from the successor memory; busy is high until the search ends.
// Results are strobed for one cycle and cannot be stalled.
// Reset clears successor counts, stack pointer and control; the memories are not cleared.

module depth_limited_graph_search #(
	parameter int NODE_COUNT = 16,
	parameter int MAX_DEGREE = 4,
	parameter int STACK_SIZE = 64,
	parameter int MAX_VISITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dls_pkg::request_t request,
	output logic              result_strobe,
	output dls_pkg::result_t  result
);

	localparam int CNT_W = $clog2(MAX_DEGREE + 1);
	localparam int VIS_W = $clog2(MAX_VISITS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_EVAL = 4'b0100,
		S_EXP  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [dls_pkg::NODE_W-1:0]  goal_q;
	logic [dls_pkg::DEPTH_W-1:0] limit_q;
	logic [VIS_W-1:0]            visits_q;
	logic [dls_pkg::NODE_W-1:0]  node_q;
	logic [dls_pkg::DEPTH_W-1:0] dnext_q;
	logic [CNT_W-1:0]            deg_q;
	logic [CNT_W-1:0]            slot_q;
	logic                        strobe_q;
	dls_pkg::result_t            result_q;

	dls_pkg::stack_cmd_t   stk_cmd;
	dls_pkg::stack_entry_t stk_wr;
	dls_pkg::stack_entry_t entry;
	logic                  stk_empty;

	logic                       add_en;
	logic                       rd_en;
	logic [dls_pkg::NODE_W-1:0] rd_node;
	logic [CNT_W-1:0]           rd_slot;
	logic [CNT_W-1:0]           deg;
	logic [dls_pkg::NODE_W-1:0] succ;

	logic              accept;
	logic              is_goal;
	logic              expand;
	logic [VIS_W-1:0]  vis_n;
	logic [CNT_W-1:0]  slot_n;
	dls_pkg::status_t  status;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign vis_n  = visits_q + VIS_W'(1);
	assign slot_n = slot_q + CNT_W'(1);

	assign is_goal = (entry.node == goal_q);
	assign expand  = !is_goal && (entry.depth < limit_q) && (deg != '0);

	// an expansion always leaves the stack non-empty, so the empty check needs no pushes
	always_comb begin
		priority if (is_goal) begin
			status = dls_pkg::ST_FOUND;
		end else if (!expand && stk_empty) begin
			status = dls_pkg::ST_NOT_FOUND;
		end else if (vis_n >= VIS_W'(MAX_VISITS)) begin
			status = dls_pkg::ST_CAP;
		end else begin
			status = dls_pkg::ST_SEARCHING;
		end
	end

	always_comb begin
		state_d      = state_q;
		stk_cmd      = '0;
		stk_wr.depth = '0;
		stk_wr.node  = request.start_node;
		add_en       = 1'b0;
		rd_en        = 1'b0;
		rd_node      = node_q;
		rd_slot      = slot_n;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (request.req_type == dls_pkg::REQ_SEARCH) begin
						stk_cmd.init = 1'b1;
						state_d      = S_POP;
					end else begin
						add_en = 1'b1;
					end
				end
			end
			S_POP: begin
				stk_cmd.pop = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				rd_node = entry.node;
				rd_slot = '0;
				rd_en   = expand;
				if (status != dls_pkg::ST_SEARCHING) begin
					state_d = S_IDLE;
				end else if (expand) begin
					state_d = S_EXP;
				end else begin
					state_d = S_POP;
				end
			end
			S_EXP: begin
				stk_cmd.push = 1'b1;
				stk_wr.depth = dnext_q;
				stk_wr.node  = succ;
				if (slot_n < deg_q) begin
					rd_en = 1'b1;
				end else begin
					state_d = S_POP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			visits_q <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == S_EVAL);
			if (stk_cmd.init) begin
				visits_q <= '0;
			end else if (state_q == S_EVAL) begin
				visits_q <= vis_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stk_cmd.init) begin
			goal_q  <= request.goal_node;
			limit_q <= request.depth_limit;
		end
		if (state_q == S_EVAL) begin
			result_q.visited_node <= entry.node;
			result_q.visit_depth  <= entry.depth;
			result_q.status       <= status;
			result_q.last         <= (status != dls_pkg::ST_SEARCHING);
			node_q                <= entry.node;
			dnext_q               <= entry.depth + dls_pkg::DEPTH_W'(1);
			deg_q                 <= deg;
			slot_q                <= '0;
		end else if (state_q == S_EXP) begin
			slot_q <= slot_n;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	dls_stack #(
		.STACK_SIZE(STACK_SIZE)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (stk_cmd),
		.wr_entry (stk_wr),
		.rd_entry (entry),
		.empty    (stk_empty)
	);

	dls_adj #(
		.NODE_COUNT(NODE_COUNT),
		.MAX_DEGREE(MAX_DEGREE)
	) u_adj (
		.clk         (clk),
		.arst_n      (arst_n),
		.add_en      (add_en),
		.add_from    (request.edge_from),
		.add_to      (request.edge_to),
		.rd_en       (rd_en),
		.rd_node     (rd_node),
		.rd_slot     (rd_slot),
		.lookup_node (entry.node),
		.deg         (deg),
		.succ        (succ)
	);

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |-> state_q == S_IDLE)
		else $error("final item strobed while search still running");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> busy)
		else $error("non-final item strobed with search stopped");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> !stk_empty)
		else $error("pop from empty stack");

	a_exp_deg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXP |-> deg_q != '0 && slot_q < deg_q)
		else $error("expansion past successor count");

endmodule
